>>> hdl/sut_pkg.sv
// Shared types and constants for the serial UART transceiver.
// No dependencies; used by sut_core, serial_uart_transceiver, sut_tb_checker and the testbench.
package sut_pkg;

    // Item kinds carried on the input channel's tuser.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_BIT_PERIOD = 1'b0;
    localparam logic CFG_LONG_MODE  = 1'b1;

    localparam int PERIOD_W     = 15;
    localparam int RX_TIMER_W   = 16;
    localparam int TX_DATA_BITS = 10;
    localparam int FRAME_BITS   = 11;
    localparam int COUNT_W      = 4;
    localparam int WORD_W       = 16;

    localparam logic [COUNT_W-1:0] FRAME_SHORT = 4'd10;
    localparam logic [COUNT_W-1:0] FRAME_LONG  = 4'd11;

    // Status word bit positions.
    localparam int ST_OVERRUN = 15;
    localparam int ST_PENDING = 14;
    localparam int ST_TBE     = 13;
    localparam int ST_TSE     = 12;
    localparam int ST_RXD     = 11;

    typedef struct packed {
        logic [1:0]        kind;
        logic [WORD_W-1:0] write_data;
        logic              rxd_line;
        logic              rbf_pending;
        logic              break_line;
    } item_t;

    typedef struct packed {
        logic              txd_line;
        logic [WORD_W-1:0] read_data;
        logic              tbe_pulse;
        logic              rbf_pulse;
    } result_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] bit_period;
        logic                long_mode;
    } config_t;

endpackage

>>> hdl/sut_core.sv
// Transmitter and receiver state of the UART, advanced by one item per accept.
// Depends on sut_pkg. Result is combinational from current state and item.
module sut_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_accept,
    input  sut_pkg::item_t      item,
    input  sut_pkg::config_t    cfg,
    output sut_pkg::result_t    result
);

    logic [sut_pkg::TX_DATA_BITS-1:0] tx_buf_reg, tx_buf_next;
    logic [sut_pkg::FRAME_BITS-1:0]   tx_sh_reg, tx_sh_next;
    logic [sut_pkg::PERIOD_W-1:0]     tx_timer_reg, tx_timer_next;
    logic                             tx_active_reg, tx_active_next;
    logic                             out_level_reg, out_level_next;
    logic [sut_pkg::FRAME_BITS-1:0]   rx_sh_reg, rx_sh_next;
    logic [sut_pkg::FRAME_BITS-1:0]   rx_buf_reg, rx_buf_next;
    logic [sut_pkg::COUNT_W-1:0]      rx_cnt_reg, rx_cnt_next;
    logic [sut_pkg::RX_TIMER_W-1:0]   rx_timer_reg, rx_timer_next;
    logic                             rx_active_reg, rx_active_next;
    logic                             overrun_reg, overrun_next;
    logic                             prev_rxd_reg, prev_rxd_next;

    logic [sut_pkg::FRAME_BITS-1:0]   tx_sh_shift;
    logic [sut_pkg::FRAME_BITS-1:0]   rx_sh_tmp;
    logic [sut_pkg::COUNT_W-1:0]      rx_cnt_inc;
    logic [sut_pkg::COUNT_W-1:0]      frame_len;
    logic                             rx_act;
    logic                             ov;
    logic [sut_pkg::RX_TIMER_W-1:0]   period_p1;
    logic [sut_pkg::RX_TIMER_W+1:0]   period_x3;
    logic [sut_pkg::RX_TIMER_W-1:0]   rx_start;

    // The first sample lands 1.5 bit periods after the falling edge.
    assign period_p1 = {1'b0, cfg.bit_period} + 1'b1;
    assign period_x3 = {2'b00, period_p1} + {1'b0, period_p1, 1'b0};
    assign rx_start  = period_x3[sut_pkg::RX_TIMER_W:1] - 1'b1;
    assign frame_len = cfg.long_mode ? sut_pkg::FRAME_LONG : sut_pkg::FRAME_SHORT;

    always_comb begin
        tx_buf_next    = tx_buf_reg;
        tx_sh_next     = tx_sh_reg;
        tx_timer_next  = tx_timer_reg;
        tx_active_next = tx_active_reg;
        out_level_next = out_level_reg;
        rx_sh_next     = rx_sh_reg;
        rx_buf_next    = rx_buf_reg;
        rx_cnt_next    = rx_cnt_reg;
        rx_timer_next  = rx_timer_reg;
        rx_active_next = rx_active_reg;
        overrun_next   = overrun_reg;
        prev_rxd_next  = prev_rxd_reg;
        tx_sh_shift    = tx_sh_reg >> 1;
        rx_sh_tmp      = rx_sh_reg;
        rx_cnt_inc     = rx_cnt_reg + 1'b1;
        rx_act         = rx_active_reg;
        ov             = item.rbf_pending & overrun_reg;
        result         = '0;

        // Sample slot for the current bit; counts of 11 and up drop the sample.
        for (int i = 0; i < sut_pkg::FRAME_BITS; i++) begin
            if (rx_cnt_reg == sut_pkg::COUNT_W'(i)) begin
                rx_sh_tmp[i] = item.rxd_line;
            end
        end

        case (item.kind)
            sut_pkg::KIND_TICK: begin
                if (tx_active_reg) begin
                    if (tx_timer_reg != '0) begin
                        tx_timer_next = tx_timer_reg - 1'b1;
                    end else begin
                        out_level_next = tx_sh_reg[0];
                        tx_sh_next     = tx_sh_shift;
                        tx_timer_next  = cfg.bit_period;
                        if (tx_sh_shift == '0) begin
                            if (tx_buf_reg != '0) begin
                                tx_sh_next       = {tx_buf_reg, 1'b0};
                                tx_buf_next      = '0;
                                result.tbe_pulse = 1'b1;
                            end else begin
                                tx_active_next = 1'b0;
                                tx_timer_next  = tx_timer_reg;
                            end
                        end
                    end
                end
                if (rx_active_reg) begin
                    if (rx_timer_reg != '0) begin
                        rx_timer_next = rx_timer_reg - 1'b1;
                    end else begin
                        rx_sh_next    = rx_sh_tmp;
                        rx_cnt_next   = rx_cnt_inc;
                        rx_timer_next = {1'b0, cfg.bit_period};
                        if (rx_cnt_inc >= frame_len) begin
                            rx_buf_next      = rx_sh_tmp;
                            rx_sh_next       = '0;
                            overrun_next     = item.rbf_pending;
                            result.rbf_pulse = 1'b1;
                            if (item.rxd_line) begin
                                rx_act = 1'b0;
                            end else begin
                                rx_cnt_next = '0;
                            end
                        end
                    end
                end
                rx_active_next = rx_act;
                if (!rx_act && !item.rxd_line && prev_rxd_reg) begin
                    rx_cnt_next    = '0;
                    rx_active_next = 1'b1;
                    rx_timer_next  = rx_start;
                end
                prev_rxd_next = item.rxd_line;
            end
            sut_pkg::KIND_WRITE: begin
                if (tx_sh_reg == '0 && item.write_data[sut_pkg::TX_DATA_BITS-1:0] != '0) begin
                    tx_sh_next       = {item.write_data[sut_pkg::TX_DATA_BITS-1:0], 1'b0};
                    tx_buf_next      = '0;
                    tx_active_next   = 1'b1;
                    tx_timer_next    = '0;
                    result.tbe_pulse = 1'b1;
                end else begin
                    tx_buf_next = item.write_data[sut_pkg::TX_DATA_BITS-1:0];
                end
            end
            sut_pkg::KIND_READ: begin
                overrun_next = ov;
                result.read_data[sut_pkg::TX_DATA_BITS-1:0] =
                    rx_buf_reg[sut_pkg::TX_DATA_BITS-1:0];
                result.read_data[sut_pkg::ST_OVERRUN] = ov;
                result.read_data[sut_pkg::ST_PENDING] = item.rbf_pending;
                result.read_data[sut_pkg::ST_TBE]     = (tx_buf_reg == '0);
                result.read_data[sut_pkg::ST_TSE]     = (tx_sh_reg == '0);
                result.read_data[sut_pkg::ST_RXD]     = item.rxd_line;
            end
            default: begin
            end
        endcase

        result.txd_line = out_level_next & ~item.break_line;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_buf_reg    <= '0;
            tx_sh_reg     <= '0;
            tx_timer_reg  <= '0;
            tx_active_reg <= 1'b0;
            out_level_reg <= 1'b1;
            rx_sh_reg     <= '0;
            rx_buf_reg    <= '0;
            rx_cnt_reg    <= '0;
            rx_timer_reg  <= '0;
            rx_active_reg <= 1'b0;
            overrun_reg   <= 1'b0;
            prev_rxd_reg  <= 1'b1;
        end else if (item_accept) begin
            tx_buf_reg    <= tx_buf_next;
            tx_sh_reg     <= tx_sh_next;
            tx_timer_reg  <= tx_timer_next;
            tx_active_reg <= tx_active_next;
            out_level_reg <= out_level_next;
            rx_sh_reg     <= rx_sh_next;
            rx_buf_reg    <= rx_buf_next;
            rx_cnt_reg    <= rx_cnt_next;
            rx_timer_reg  <= rx_timer_next;
            rx_active_reg <= rx_active_next;
            overrun_reg   <= overrun_next;
            prev_rxd_reg  <= prev_rxd_next;
        end
    end

endmodule

>>> hdl/serial_uart_transceiver.sv
// UART transceiver stepped one transaction at a time: a tick, a data write or a
// status read. Each accepted transaction yields exactly one result in the next
// cycle from a single output register; a new transaction is taken every cycle
// as long as that register is empty or being drained, so the sustained rate is
// one item per clock. The bit period counters advance only on tick transactions.
// Depends on sut_pkg and sut_core.
module serial_uart_transceiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // write_data[15:0], rxd_line, rbf_pending, break_line, zeros
    input  logic [1:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // txd_line, read_data[15:0], tbe_pulse, rbf_pulse, zeros
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [14:0] cfg_data
);

    sut_pkg::config_t cfg_reg;
    sut_pkg::item_t   item;
    sut_pkg::result_t result;
    logic             accept;
    logic             m_tvalid_reg;
    logic [23:0]      m_tdata_reg;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign item.kind        = s_tuser;
    assign item.write_data  = s_tdata[15:0];
    assign item.rxd_line    = s_tdata[16];
    assign item.rbf_pending = s_tdata[17];
    assign item.break_line  = s_tdata[18];

    sut_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_accept (accept),
        .item        (item),
        .cfg         (cfg_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                sut_pkg::CFG_BIT_PERIOD: cfg_reg.bit_period <= cfg_data;
                sut_pkg::CFG_LONG_MODE:  cfg_reg.long_mode  <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {5'b00000, result.rbf_pulse, result.tbe_pulse,
                            result.read_data, result.txd_line};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> hdl/sut_checker.sv
// Port-level checks for serial_uart_transceiver, attached by bind.
// Depends only on the top level's ports.
module sut_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // Reset empties the result register.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Every accepted transaction produces a result on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted transaction produced no result");

    // The input side is never held off while the result register is empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // Reserved status bit and padding are always zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[11] == 1'b0 && m_tdata[23:19] == 5'b00000))
        else $error("reserved result bits set");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind serial_uart_transceiver sut_checker u_sut_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/sut_checker.sv
`timescale 1ns / 100ps
// Checker for the serial UART transceiver: watches the input, result and configuration
// channels, predicts each result and compares it field by field. Depends on sut_pkg.
module sut_tb_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [14:0] cfg_data,
    output int          mismatches,
    output int          results_owed
);

    // Predicted configuration and UART state.
    logic [14:0] bit_period_q;
    logic        long_mode_q;
    logic [9:0]  tx_buf;
    logic [10:0] tx_shift;
    logic [15:0] tx_count;
    logic        tx_busy;
    logic        line_level;
    logic [10:0] rx_shift;
    logic [10:0] rx_hold;
    logic [3:0]  rx_index;
    logic [16:0] rx_count;
    logic        rx_busy;
    logic        overrun_q;
    logic        last_rxd;

    sut_pkg::result_t uart_results_due[$];
    sut_pkg::item_t   in_item;
    sut_pkg::result_t got_r;
    sut_pkg::result_t want_r;

    task automatic step_uart(input sut_pkg::item_t it, output sut_pkg::result_t r);
        logic [3:0] frame_len;
        int         span;
        r = '0;
        case (it.kind)
            sut_pkg::KIND_TICK: begin
                if (tx_busy) begin
                    if (tx_count != 0) begin
                        tx_count = tx_count - 1'b1;
                    end else begin
                        line_level = tx_shift[0];
                        tx_shift = tx_shift >> 1;
                        if (tx_shift == 0 && tx_buf == 0) begin
                            tx_busy = 1'b0;
                        end else begin
                            // Back-to-back frames: the buffer follows without a gap.
                            if (tx_shift == 0) begin
                                tx_shift = {tx_buf, 1'b0};
                                tx_buf = '0;
                                r.tbe_pulse = 1'b1;
                            end
                            tx_count = 16'(bit_period_q);
                        end
                    end
                end
                if (rx_busy) begin
                    if (rx_count != 0) begin
                        rx_count = rx_count - 1'b1;
                    end else begin
                        frame_len = long_mode_q ? sut_pkg::FRAME_LONG : sut_pkg::FRAME_SHORT;
                        if (rx_index < sut_pkg::FRAME_BITS)
                            rx_shift[rx_index] = it.rxd_line;
                        rx_index = rx_index + 1'b1;
                        rx_count = 17'(bit_period_q);
                        if (rx_index >= frame_len) begin
                            rx_hold = rx_shift;
                            rx_shift = '0;
                            overrun_q = it.rbf_pending;
                            r.rbf_pulse = 1'b1;
                            // A low final sample runs straight into the next frame.
                            if (it.rxd_line)
                                rx_busy = 1'b0;
                            else
                                rx_index = '0;
                        end
                    end
                end
                if (!rx_busy && !it.rxd_line && last_rxd) begin
                    span = int'(bit_period_q) + 1;
                    rx_index = '0;
                    rx_busy = 1'b1;
                    rx_count = 17'((span * 3) / 2 - 1);
                end
                last_rxd = it.rxd_line;
            end
            sut_pkg::KIND_WRITE: begin
                tx_buf = it.write_data[9:0];
                if (tx_shift == 0 && tx_buf != 0) begin
                    tx_shift = {tx_buf, 1'b0};
                    tx_buf = '0;
                    r.tbe_pulse = 1'b1;
                    tx_busy = 1'b1;
                    tx_count = '0;
                end
            end
            sut_pkg::KIND_READ: begin
                if (!it.rbf_pending)
                    overrun_q = 1'b0;
                r.read_data = {overrun_q, it.rbf_pending, tx_buf == 0, tx_shift == 0,
                               it.rxd_line, 1'b0, rx_hold[9:0]};
            end
            default: ;
        endcase
        r.txd_line = line_level & ~it.break_line;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            bit_period_q = '0;
            long_mode_q  = 1'b0;
            tx_buf       = '0;
            tx_shift     = '0;
            tx_count     = '0;
            tx_busy      = 1'b0;
            line_level   = 1'b1;
            rx_shift     = '0;
            rx_hold      = '0;
            rx_index     = '0;
            rx_count     = '0;
            rx_busy      = 1'b0;
            overrun_q    = 1'b0;
            last_rxd     = 1'b1;
            uart_results_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got_r.txd_line  = m_tdata[0];
                got_r.read_data = m_tdata[16:1];
                got_r.tbe_pulse = m_tdata[17];
                got_r.rbf_pulse = m_tdata[18];
                if (uart_results_due.size() == 0) begin
                    $error("result transaction with no prediction waiting");
                    mismatches++;
                end else begin
                    want_r = uart_results_due.pop_front();
                    if (got_r.txd_line !== want_r.txd_line) begin
                        $error("txd_line: expected %0d, actual %0d",
                               want_r.txd_line, got_r.txd_line);
                        mismatches++;
                    end
                    if (got_r.read_data !== want_r.read_data) begin
                        $error("read_data: expected 0x%04h, actual 0x%04h",
                               want_r.read_data, got_r.read_data);
                        mismatches++;
                    end
                    if (got_r.tbe_pulse !== want_r.tbe_pulse) begin
                        $error("tbe_pulse: expected %0d, actual %0d",
                               want_r.tbe_pulse, got_r.tbe_pulse);
                        mismatches++;
                    end
                    if (got_r.rbf_pulse !== want_r.rbf_pulse) begin
                        $error("rbf_pulse: expected %0d, actual %0d",
                               want_r.rbf_pulse, got_r.rbf_pulse);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == sut_pkg::CFG_BIT_PERIOD)
                    bit_period_q = cfg_data;
                else
                    long_mode_q = cfg_data[0];
            end
            if (s_tvalid && s_tready) begin
                in_item.kind        = s_tuser;
                in_item.write_data  = s_tdata[15:0];
                in_item.rxd_line    = s_tdata[16];
                in_item.rbf_pending = s_tdata[17];
                in_item.break_line  = s_tdata[18];
                step_uart(in_item, want_r);
                uart_results_due.push_back(want_r);
            end
        end
        results_owed = uart_results_due.size();
    end

    initial begin
        mismatches   = 0;
        results_owed = 0;
    end

endmodule

>>> tb/serial_uart_transceiver_tb.sv
`timescale 1ns / 100ps
// Top of the serial UART transceiver testbench: clock, reset, stimulus and verdict.
// Depends on sut_pkg, serial_uart_transceiver and sut_tb_checker.
module serial_uart_transceiver_tb;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    // Sampled receive bits for the directed frame, first sample in bit 0.
    localparam logic [9:0] RX_PATTERN  = 10'b11_0110_1001;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [14:0] cfg_data;
    int          mismatches;
    int          results_owed;

    bit          hold_req;
    int          burst_left;
    int unsigned cur_period;
    bit          cur_long;
    logic        line_now;
    logic        line_plan[$];

    serial_uart_transceiver uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sut_tb_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .results_owed (results_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("serial_uart_transceiver_tb: done, errors");
        $finish;
    end

    // Result side: a stall style is drawn anew each time its phase runs out; a
    // requested long hold-off lets the block fill up and push back on its input.
    initial begin
        int phase_left;
        int style;
        int beat;
        m_tready   = 1'b0;
        phase_left = 0;
        style      = 0;
        beat       = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            if (phase_left == 0) begin
                style      = $urandom_range(0, 2);
                phase_left = $urandom_range(32, 256);
            end
            phase_left--;
            beat++;
            case (style)
                0: m_tready = 1'b1;
                1: m_tready = ($urandom_range(0, 2) != 0);
                default: m_tready = ((beat % 5) < 2);
            endcase
        end
    end

    // Plans the receive line as well-formed frames at the current bit time, with
    // bursts of noise instead now and then, and always above a bit period of 63.
    function automatic void plan_frame();
        int unsigned span;
        int unsigned nbits;
        logic [10:0] payload;
        span = cur_period + 1;
        if (cur_period > 63 || $urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 24)) line_plan.push_back(1'($urandom_range(0, 1)));
            return;
        end
        nbits   = cur_long ? 11 : 10;
        payload = 11'($urandom);
        if ($urandom_range(0, 5) != 0) begin
            payload[nbits - 1] = 1'b1;
            payload[nbits - 2] = 1'b1;
        end
        repeat (span) line_plan.push_back(1'b0);
        for (int i = 0; i < nbits; i++)
            repeat (span) line_plan.push_back(payload[i]);
        repeat ($urandom_range(0, 2 * span)) line_plan.push_back(1'b1);
    endfunction

    function automatic sut_pkg::item_t random_item();
        sut_pkg::item_t it;
        int unsigned    pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            it.kind = sut_pkg::KIND_TICK;
        else if (pick < 82)
            it.kind = sut_pkg::KIND_WRITE;
        else if (pick < 97)
            it.kind = sut_pkg::KIND_READ;
        else
            it.kind = KIND_UNUSED;
        case ($urandom_range(0, 7))
            0: it.write_data = '0;
            1: it.write_data = {6'($urandom), 10'd0};
            2: it.write_data = '1;
            default: it.write_data = 16'($urandom);
        endcase
        if (it.kind == sut_pkg::KIND_TICK) begin
            if (line_plan.size() == 0)
                plan_frame();
            line_now = line_plan.pop_front();
            it.rxd_line = line_now;
        end else begin
            it.rxd_line = ($urandom_range(0, 7) == 0) ? 1'($urandom) : line_now;
        end
        it.rbf_pending = 1'($urandom);
        it.break_line  = ($urandom_range(0, 9) == 0);
        return it;
    endfunction

    // Offers one item; the sender runs in bursts, often with idle gaps between them.
    task automatic send_item(input sut_pkg::item_t it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {5'd0, it.break_line, it.rbf_pending, it.rxd_line, it.write_data};
        s_tuser  = it.kind;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_fields(input logic [1:0] k, input logic [15:0] wd,
                               input logic rxd, input logic pend, input logic brk);
        sut_pkg::item_t it;
        it.kind        = k;
        it.write_data  = wd;
        it.rxd_line    = rxd;
        it.rbf_pending = pend;
        it.break_line  = brk;
        send_item(it);
    endtask

    // Registers change only once every predicted result has come back.
    task automatic write_reg(input logic idx, input logic [14:0] val);
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (results_owed != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_phase(input int unsigned period, input bit lng, input int count);
        write_reg(sut_pkg::CFG_BIT_PERIOD, 15'(period));
        write_reg(sut_pkg::CFG_LONG_MODE, {14'($urandom), lng});
        cur_period = period;
        cur_long   = lng;
        line_plan.delete();
        repeat (count) send_item(random_item());
    endtask

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = sut_pkg::KIND_TICK;
        cfg_valid  = 1'b0;
        cfg_index  = sut_pkg::CFG_BIT_PERIOD;
        cfg_data   = '0;
        hold_req   = 1'b0;
        burst_left = 0;
        cur_period = 0;
        cur_long   = 1'b0;
        line_now   = 1'b1;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: status after reset, buffer loads including all-zero data,
        // break, one received frame with overrun and its clearing, unused kind.
        send_fields(sut_pkg::KIND_READ, 16'h0000, 1'b1, 1'b0, 1'b0);
        send_fields(sut_pkg::KIND_WRITE, 16'hFFFF, 1'b1, 1'b1, 1'b0);
        send_fields(sut_pkg::KIND_WRITE, 16'h0000, 1'b1, 1'b0, 1'b1);
        send_fields(sut_pkg::KIND_WRITE, 16'hFC00, 1'b1, 1'b0, 1'b0);
        send_fields(sut_pkg::KIND_READ, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        send_fields(sut_pkg::KIND_TICK, 16'h0000, 1'b1, 1'b0, 1'b1);
        send_fields(sut_pkg::KIND_TICK, 16'h0000, 1'b0, 1'b1, 1'b0);
        for (int i = 0; i < 10; i++)
            send_fields(sut_pkg::KIND_TICK, 16'($urandom), RX_PATTERN[i], 1'b1, 1'b0);
        send_fields(sut_pkg::KIND_READ, 16'h0000, 1'b0, 1'b1, 1'b0);
        send_fields(sut_pkg::KIND_READ, 16'h0000, 1'b1, 1'b0, 1'b0);
        send_fields(KIND_UNUSED, 16'hFFFF, 1'b1, 1'b1, 1'b1);

        run_phase(0, 1'b1, 300);
        run_phase(1, 1'b0, 300);
        run_phase(32767, 1'b1, 60);
        run_phase(2, 1'b0, 300);
        run_phase(0, 1'b0, 100);
        // The result side holds off while the sender keeps offering.
        burst_left = 60;
        hold_req   = 1'b1;
        repeat (60) send_item(random_item());
        run_phase(3, 1'b1, 300);
        run_phase(5, 1'b0, 250);
        run_phase(1, 1'b1, 300);

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (results_owed != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (mismatches == 0 && results_owed == 0)
            $display("serial_uart_transceiver_tb: done, clean");
        else
            $display("serial_uart_transceiver_tb: done, errors");
        $finish;
    end

endmodule
